>>> design/cubic_bezier_flattener_unit_defines.svh
// Assertion macros for the cubic Bezier flattener.
// Included by files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef CUBIC_BEZIER_FLATTENER_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_FLATTENER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cbf_pkg.sv
// Shared types and constants for the cubic Bezier flattener.
// No dependencies; used by cbf_axis and cubic_bezier_flattener_unit.
package cbf_pkg;

  localparam int unsigned COORD_BITS           = 16;
  localparam int unsigned SEG_W                = 6;
  localparam int unsigned COEF_W               = COORD_BITS + 4;
  localparam int unsigned MAX_SEGMENTS_DEF     = 63;
  localparam int unsigned PARAM_FRAC_BITS_DEF  = 16;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] ctrl1_x;
    logic signed [COORD_BITS-1:0] ctrl1_y;
    logic signed [COORD_BITS-1:0] ctrl2_x;
    logic signed [COORD_BITS-1:0] ctrl2_y;
    logic        [SEG_W-1:0]      segment_count;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } out_item_t;

  // per-stage control that travels with each point
  typedef struct packed {
    logic valid;
    logic last;
    logic bypass;
  } ctl_t;

endpackage

>>> design/cubic_bezier_flattener_unit.sv
// Cubic Bezier flattener: a request with N segments (N = 0 gives nothing) yields
// N+1 points, start point first and end point last (marked). The request is held
// in a point sequencer that issues one point per cycle unless the output stalls;
// the next request is taken once the last point has been issued. Each point runs
// through a five-stage evaluator (three Horner multiply stages, recombine/round,
// output register). Output stall freezes the whole evaluator.
// Depends on cbf_pkg, cbf_axis and cubic_bezier_flattener_unit_defines.svh.
`include "cubic_bezier_flattener_unit_defines.svh"

module cubic_bezier_flattener_unit #(
  parameter int unsigned MAX_SEGMENTS    = cbf_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = cbf_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cbf_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cbf_pkg::out_item_t  out_item
);

  localparam int unsigned SW   = cbf_pkg::SEG_W;
  localparam int unsigned CW   = cbf_pkg::COEF_W;
  localparam int unsigned XW   = cbf_pkg::COORD_BITS;
  localparam int unsigned QW   = PARAM_FRAC_BITS + 1;
  localparam int unsigned NTOP = (2 ** SW) - 1;
  localparam int unsigned NCAP = (MAX_SEGMENTS < NTOP) ? MAX_SEGMENTS : NTOP;

  function automatic logic signed [CW-1:0] triple(input logic signed [CW-1:0] v);
    return (v <<< 1) + v;
  endfunction

  // step table: floor(2^F / n)
  logic [QW-1:0] recip [2 ** SW];
  assign recip[0] = '0;
  for (genvar gn = 1; gn < 2 ** SW; gn++) begin : g_recip
    localparam logic [QW-1:0] QV = QW'((64'd1 << PARAM_FRAC_BITS) / gn);
    assign recip[gn] = QV;
  end

  // request decode
  logic [SW-1:0]          n_in;
  logic                   accept;
  logic                   run_start;
  logic signed [CW-1:0]   sx, sy, ex, ey, c1x, c1y, c2x, c2y;
  logic signed [CW-1:0]   cub_x, cub_y, sqr_x, sqr_y, lin_x, lin_y;

  // point sequencer
  logic                   busy_r, busy_nxt;
  logic [SW-1:0]          idx_r, idx_nxt;
  logic [SW-1:0]          n_r;
  logic [QW-1:0]          q_r;
  logic [QW-1:0]          t_r, t_nxt;
  logic signed [CW-1:0]   cub_x_r, cub_y_r, sqr_x_r, sqr_y_r, lin_x_r, lin_y_r;
  logic signed [XW-1:0]   start_x_r, start_y_r, end_x_r, end_y_r;
  logic                   issue_last;
  cbf_pkg::ctl_t          issue_ctl;

  // evaluator control
  logic                   adv;
  cbf_pkg::ctl_t          ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r;
  logic                   out_valid_r;
  cbf_pkg::out_item_t     out_item_r;
  logic signed [XW-1:0]   base_x, base_y, coord_x, coord_y;

  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;
  assign n_in      = (in_item.segment_count > SW'(NCAP)) ? SW'(NCAP) : in_item.segment_count;
  assign run_start = accept && (n_in != '0);

  always_comb begin
    sx    = CW'(in_item.start_x);
    sy    = CW'(in_item.start_y);
    ex    = CW'(in_item.end_x);
    ey    = CW'(in_item.end_y);
    c1x   = CW'(in_item.ctrl1_x);
    c1y   = CW'(in_item.ctrl1_y);
    c2x   = CW'(in_item.ctrl2_x);
    c2y   = CW'(in_item.ctrl2_y);
    cub_x = ex - sx + triple(c1x - c2x);
    cub_y = ey - sy + triple(c1y - c2y);
    sqr_x = triple(sx - (c1x <<< 1) + c2x);
    sqr_y = triple(sy - (c1y <<< 1) + c2y);
    lin_x = triple(c1x - sx);
    lin_y = triple(c1y - sy);
  end

  assign adv        = !out_valid_r || !out_stall;
  assign issue_last = (idx_r == n_r);

  always_comb begin
    issue_ctl.valid  = busy_r;
    issue_ctl.last   = busy_r && issue_last;
    issue_ctl.bypass = (idx_r == '0) || issue_last;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    t_nxt    = t_r;
    priority if (run_start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      t_nxt    = recip[n_in];
    end else if (busy_r && adv) begin
      if (issue_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + SW'(1);
      end
      if (idx_r != '0 && !issue_last) begin
        t_nxt = t_r + q_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      t_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      t_r    <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      n_r       <= n_in;
      q_r       <= recip[n_in];
      cub_x_r   <= cub_x;
      cub_y_r   <= cub_y;
      sqr_x_r   <= sqr_x;
      sqr_y_r   <= sqr_y;
      lin_x_r   <= lin_x;
      lin_y_r   <= lin_y;
      start_x_r <= in_item.start_x;
      start_y_r <= in_item.start_y;
      end_x_r   <= in_item.end_x;
      end_y_r   <= in_item.end_y;
    end
  end

  assign base_x = issue_last ? end_x_r : start_x_r;
  assign base_y = issue_last ? end_y_r : start_y_r;

  cbf_axis #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_axis_x (
    .clk      (clk),
    .en       (adv),
    .cubic    (cub_x_r),
    .square   (sqr_x_r),
    .linear   (lin_x_r),
    .base     (base_x),
    .t        (t_r[PARAM_FRAC_BITS-1:0]),
    .bypass_d (ctl_d_r.bypass),
    .coord    (coord_x)
  );

  cbf_axis #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_axis_y (
    .clk      (clk),
    .en       (adv),
    .cubic    (cub_y_r),
    .square   (sqr_y_r),
    .linear   (lin_y_r),
    .base     (base_y),
    .t        (t_r[PARAM_FRAC_BITS-1:0]),
    .bypass_d (ctl_d_r.bypass),
    .coord    (coord_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r     <= '0;
      ctl_b_r     <= '0;
      ctl_c_r     <= '0;
      ctl_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl_a_r     <= issue_ctl;
      ctl_b_r     <= ctl_a_r;
      ctl_c_r     <= ctl_b_r;
      ctl_d_r     <= ctl_c_r;
      out_valid_r <= ctl_d_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.point_x    <= coord_x;
      out_item_r.point_y    <= coord_y;
      out_item_r.last_point <= ctl_d_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CBF_ASSERT_NOW(a_idx_bound, busy_r, idx_r <= n_r, "point index past segment count")
  `CBF_ASSERT_NOW(a_t_range, busy_r && !issue_ctl.bypass, !t_r[QW-1], "interior t reached one")
  `CBF_ASSERT_NEXT(a_run_end, busy_r && issue_last && adv, !busy_r, "busy after end point")
  `CBF_ASSERT_NOW(a_last_bypass, ctl_d_r.last, ctl_d_r.bypass, "end point not bypassed")

endmodule

>>> design/cbf_axis.sv
// One coordinate of the curve evaluator: Horner pipeline, rounding and saturation.
// Depends on cbf_pkg.
module cbf_axis #(
  parameter int unsigned PARAM_FRAC_BITS = cbf_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [cbf_pkg::COEF_W-1:0]       cubic,
  input  logic signed [cbf_pkg::COEF_W-1:0]       square,
  input  logic signed [cbf_pkg::COEF_W-1:0]       linear,
  input  logic signed [cbf_pkg::COORD_BITS-1:0]   base,
  input  logic        [PARAM_FRAC_BITS-1:0]       t,
  input  logic                                    bypass_d,
  output logic signed [cbf_pkg::COORD_BITS-1:0]   coord
);

  localparam int unsigned F    = PARAM_FRAC_BITS;
  localparam int unsigned XW   = cbf_pkg::COORD_BITS;
  localparam int unsigned CW   = cbf_pkg::COEF_W;
  localparam int unsigned A1_W = CW + F + 1;
  localparam int unsigned A2_W = A1_W + F + 1;
  localparam int unsigned LO_W = A2_W / 2;
  localparam int unsigned HI_W = A2_W - LO_W;
  localparam int unsigned A3_W = A2_W + F;
  localparam int unsigned V_W  = A3_W - 3 * F;
  localparam logic [A3_W-1:0]      RND  = A3_W'(1) << (3 * F - 1);
  localparam logic signed [V_W:0]  SMAX = (V_W + 1)'((2 ** (XW - 1)) - 1);
  localparam logic signed [V_W:0]  SMIN = (V_W + 1)'(-(2 ** (XW - 1)));

  // stage A: a*t + b*2^F
  logic signed [A1_W-1:0]   prod_a;
  logic signed [A1_W-1:0]   acc1_nxt;
  logic signed [A1_W-1:0]   acc1_r;
  logic signed [CW-1:0]     lin_a_r;
  logic signed [XW-1:0]     base_a_r;
  logic        [F-1:0]      t_a_r;

  // stage B: acc1*t + c*2^2F
  logic signed [A2_W-1:0]   prod_b;
  logic signed [A2_W-1:0]   acc2_nxt;
  logic signed [A2_W-1:0]   acc2_r;
  logic signed [XW-1:0]     base_b_r;
  logic        [F-1:0]      t_b_r;

  // stage C: acc2*t split in two partial products
  logic        [LO_W-1:0]     lo_part;
  logic signed [HI_W-1:0]     hi_part;
  logic        [LO_W+F-1:0]   plo_nxt;
  logic signed [HI_W+F-1:0]   phi_nxt;
  logic        [LO_W+F-1:0]   plo_r;
  logic signed [HI_W+F-1:0]   phi_r;
  logic signed [XW-1:0]       base_c_r;

  // stage D: recombine, round, scale
  logic signed [A3_W-1:0]   acc3;
  logic signed [V_W-1:0]    val_nxt;
  logic signed [V_W-1:0]    val_r;
  logic signed [XW-1:0]     base_d_r;
  logic signed [V_W:0]      sum;

  assign prod_a   = cubic * $signed({1'b0, t});
  assign acc1_nxt = prod_a + (A1_W'(square) <<< F);

  assign prod_b   = acc1_r * $signed({1'b0, t_a_r});
  assign acc2_nxt = prod_b + (A2_W'(lin_a_r) <<< (2 * F));

  assign lo_part  = acc2_r[LO_W-1:0];
  assign hi_part  = $signed(acc2_r[A2_W-1:LO_W]);
  assign plo_nxt  = lo_part * t_b_r;
  assign phi_nxt  = hi_part * $signed({1'b0, t_b_r});

  always_comb begin
    acc3    = (A3_W'(phi_r) <<< LO_W) + $signed(A3_W'(plo_r)) + $signed(RND);
    val_nxt = V_W'(acc3 >>> (3 * F));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc1_r   <= acc1_nxt;
      lin_a_r  <= linear;
      base_a_r <= base;
      t_a_r    <= t;
      acc2_r   <= acc2_nxt;
      base_b_r <= base_a_r;
      t_b_r    <= t_a_r;
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
      base_c_r <= base_b_r;
      val_r    <= val_nxt;
      base_d_r <= base_c_r;
    end
  end

  assign sum = (V_W + 1)'(val_r) + (V_W + 1)'(base_d_r);

  always_comb begin
    priority if (bypass_d) begin
      coord = base_d_r;
    end else if (sum > SMAX) begin
      coord = SMAX[XW-1:0];
    end else if (sum < SMIN) begin
      coord = SMIN[XW-1:0];
    end else begin
      coord = sum[XW-1:0];
    end
  end

endmodule

>>> test/tb_cubic_bezier_flattener_unit.sv
// Testbench for cubic_bezier_flattener_unit: drives curve requests, predicts every point
// in exact integer arithmetic and checks each output item in order.
// Depends on cbf_pkg and the RTL of cubic_bezier_flattener_unit.
module tb_cubic_bezier_flattener_unit;

  localparam int unsigned COORD_BITS = cbf_pkg::COORD_BITS;
  localparam int unsigned SEG_W = cbf_pkg::SEG_W;
  localparam int MAX_SEG = int'(cbf_pkg::MAX_SEGMENTS_DEF);
  localparam int FRAC = int'(cbf_pkg::PARAM_FRAC_BITS_DEF);
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PER_PHASE = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cbf_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cbf_pkg::out_item_t out_item;

  cbf_pkg::in_item_t request_q[$];
  cbf_pkg::out_item_t curve_points_q[$];
  int mismatch_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;

  cubic_bezier_flattener_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("cubic_bezier_flattener_unit verification failed");
    $finish;
  end

  function automatic logic signed [COORD_BITS-1:0] curve_coord(longint base, longint a,
                                                               longint b, longint c,
                                                               longint t);
    logic signed [127:0] wa, wb, wc, wt, acc;
    longint v;
    wa = 128'(a);
    wb = 128'(b);
    wc = 128'(c);
    wt = 128'(t);
    acc = ((wa * wt + (wb <<< FRAC)) * wt + (wc <<< (2 * FRAC))) * wt
          + (128'sd1 <<< (3 * FRAC - 1));
    v = base + longint'(acc >>> (3 * FRAC));
    if (v > COORD_MAX) v = COORD_MAX;
    else if (v < COORD_MIN) v = COORD_MIN;
    return COORD_BITS'(v);
  endfunction

  task automatic add_request(cbf_pkg::in_item_t r);
    request_q.insert(request_q.size(), r);
  endtask

  task automatic add_point(cbf_pkg::out_item_t p);
    curve_points_q.insert(curve_points_q.size(), p);
  endtask

  task automatic plan_curve(cbf_pkg::in_item_t req);
    longint sx, sy, ex, ey, c1x, c1y, c2x, c2y;
    longint ax, ay, bx, by, cx, cy, q, t;
    int n;
    cbf_pkg::out_item_t pt;
    n = int'(req.segment_count);
    if (n == 0) return;
    if (n > MAX_SEG) n = MAX_SEG;
    sx = longint'($signed(req.start_x));
    sy = longint'($signed(req.start_y));
    ex = longint'($signed(req.end_x));
    ey = longint'($signed(req.end_y));
    c1x = longint'($signed(req.ctrl1_x));
    c1y = longint'($signed(req.ctrl1_y));
    c2x = longint'($signed(req.ctrl2_x));
    c2y = longint'($signed(req.ctrl2_y));
    ax = ex - sx + 3 * (c1x - c2x);
    ay = ey - sy + 3 * (c1y - c2y);
    bx = 3 * (sx - 2 * c1x + c2x);
    by = 3 * (sy - 2 * c1y + c2y);
    cx = 3 * (c1x - sx);
    cy = 3 * (c1y - sy);
    q = (longint'(1) << FRAC) / longint'(n);
    pt.point_x = req.start_x;
    pt.point_y = req.start_y;
    pt.last_point = 1'b0;
    add_point(pt);
    t = 0;
    for (int i = 1; i < n; i++) begin
      t += q;
      pt.point_x = curve_coord(sx, ax, bx, cx, t);
      pt.point_y = curve_coord(sy, ay, by, cy, t);
      add_point(pt);
    end
    pt.point_x = req.end_x;
    pt.point_y = req.end_y;
    pt.last_point = 1'b1;
    add_point(pt);
  endtask

  task automatic note_mismatch(string msg);
    $display("point mismatch: %s", msg);
    mismatch_count++;
  endtask

  // sender: one gap draw per item, counted after acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) plan_curve(in_item);
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (request_q.size() != 0) begin
          in_item <= request_q.pop_front();
          in_valid <= 1'b1;
          send_wait <= send_gaps ? int'($urandom_range(0, 9)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: per-item waits plus long holds on request
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
      hold_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      draw = recv_gaps ? int'($urandom_range(0, 9)) : 0;
      out_stall <= (draw != 0);
      recv_wait <= (draw != 0) ? draw - 1 : 0;
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cbf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (curve_points_q.size() == 0) begin
        note_mismatch($sformatf("unexpected item (%0d,%0d) last=%0b",
                                out_item.point_x, out_item.point_y, out_item.last_point));
      end else begin
        want = curve_points_q.pop_front();
        if (out_item.point_x !== want.point_x)
          note_mismatch($sformatf("point_x %0d, expected %0d", out_item.point_x, want.point_x));
        if (out_item.point_y !== want.point_y)
          note_mismatch($sformatf("point_y %0d, expected %0d", out_item.point_y, want.point_y));
        if (out_item.last_point !== want.last_point)
          note_mismatch($sformatf("last_point %0b, expected %0b",
                                  out_item.last_point, want.last_point));
      end
    end
  end

  function automatic logic signed [COORD_BITS-1:0] coord_near(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > COORD_MAX) v = int'(COORD_MAX);
    if (v < COORD_MIN) v = int'(COORD_MIN);
    return COORD_BITS'(v);
  endfunction

  function automatic cbf_pkg::in_item_t random_request();
    cbf_pkg::in_item_t r;
    int cx, cy, spread, pick;
    pick = int'($urandom_range(0, 9));
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    spread = (pick < 2) ? 65535 : ((pick < 6) ? 200 : 4000);
    r.start_x = coord_near(cx, spread);
    r.start_y = coord_near(cy, spread);
    r.end_x = coord_near(cx, spread);
    r.end_y = coord_near(cy, spread);
    r.ctrl1_x = coord_near(cx, spread);
    r.ctrl1_y = coord_near(cy, spread);
    r.ctrl2_x = coord_near(cx, spread);
    r.ctrl2_y = coord_near(cy, spread);
    pick = int'($urandom_range(0, 19));
    if (pick == 0) r.segment_count = '0;
    else if (pick < 15) r.segment_count = SEG_W'($urandom_range(1, 12));
    else r.segment_count = SEG_W'($urandom_range(13, 63));
    return r;
  endfunction

  task automatic queue_request(int sx, int sy, int ex, int ey, int c1x, int c1y,
                               int c2x, int c2y, int n);
    cbf_pkg::in_item_t r;
    r.start_x = COORD_BITS'(sx);
    r.start_y = COORD_BITS'(sy);
    r.end_x = COORD_BITS'(ex);
    r.end_y = COORD_BITS'(ey);
    r.ctrl1_x = COORD_BITS'(c1x);
    r.ctrl1_y = COORD_BITS'(c1y);
    r.ctrl2_x = COORD_BITS'(c2x);
    r.ctrl2_y = COORD_BITS'(c2y);
    r.segment_count = SEG_W'(n);
    add_request(r);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || curve_points_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_request(100, -200, 300, 400, 50, 60, 70, 80, 0);
    queue_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_request(0, 0, 0, 0, 0, 0, 0, 0, 1);
    queue_request(-5, 7, 900, -800, 30, 40, 600, -500, 1);
    // ties at the midpoint: +1.5 rounds up, -1.5 rounds up to -1
    queue_request(0, 0, 3, -3, 1, -1, 2, -2, 2);
    queue_request(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 63);
    queue_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 63);
    queue_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 5);
    queue_request(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768, 40);
    queue_request(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 62);
    queue_request(10, 20, 30, 40, 50, 60, 70, 80, 3);
    queue_request(-1000, 2000, 3000, -4000, 5000, 6000, -7000, 8000, 4);
    queue_request(1, -1, -1, 1, 32767, -32768, -32768, 32767, 7);
    queue_request(0, 0, 1000, 0, 0, 1000, 1000, 1000, 32);
    wait_drained();

    for (int i = 0; i < RANDOM_PER_PHASE; i++) add_request(random_request());
    repeat (50) @(negedge clk);
    hold_ticket++;
    wait_drained();

    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) add_request(random_request());
    wait_drained();

    recv_gaps = 1'b1;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) add_request(random_request());
    repeat (200) @(negedge clk);
    hold_ticket++;
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("cubic_bezier_flattener_unit verification clean");
    else
      $display("cubic_bezier_flattener_unit verification failed");
    $finish;
  end

endmodule
